// ===== src/bptc_pkg.sv =====
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared widths, register indexes and sequencer step codes for the
// barometric second-order compensation unit.
// ----------------------------------------------------------------------------
package bptc_pkg;

    localparam int CAL_N    = 6;
    localparam int CAL_W    = 16;
    localparam int IDX_W    = 3;
    localparam int RAW_W    = 24;
    localparam int VAL_W    = 32;
    localparam int DT_W     = 26;
    localparam int MW       = 66;   // accumulator, exact for every product here
    localparam int BW       = 33;   // serial multiplier operand
    localparam int CNT_W    = 6;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(BW - 1);

    localparam logic [IDX_W-1:0] REG_C1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_C2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_C3 = 3'd2;
    localparam logic [IDX_W-1:0] REG_C4 = 3'd3;
    localparam logic [IDX_W-1:0] REG_C5 = 3'd4;
    localparam logic [IDX_W-1:0] REG_C6 = 3'd5;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic signed [VAL_W-1:0] TEMP_KNEE = 32'sd2000;
    localparam logic signed [VAL_W-1:0] COLD_KNEE = -32'sd1500;

    localparam logic [2:0] STEP_T_COEF   = 3'd0;
    localparam logic [2:0] STEP_T_SQ     = 3'd1;
    localparam logic [2:0] STEP_P_OFF    = 3'd2;
    localparam logic [2:0] STEP_P_SENS   = 3'd3;
    localparam logic [2:0] STEP_P_SQ     = 3'd4;
    localparam logic [2:0] STEP_P_SQ2_OF = 3'd5;
    localparam logic [2:0] STEP_P_SQ2_SN = 3'd6;
    localparam logic [2:0] STEP_P_FINAL  = 3'd7;

endpackage

// ===== src/baro_pressure_temp_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Second-order compensation of raw temperature and pressure conversions,
// built around one bit-serial shift-add multiplier.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                               | word
//  s_axis   | in  | s_tvalid s_tready s_tdata s_tuser     | raw sample, kind
//  m_axis   | out | m_tvalid m_tready m_tdata m_tuser     | result, kind, held
//  cfg      | in  | cfg_valid cfg_ready cfg_index cfg_data| calibration word
//
//  Each product is a load, then 33 serial bits of the multiplier.
//  Squared terms run only below the knees; a zero raw word skips the multiplier.
//  One word is in work at a time; the next is taken once the result is
//  handed to the output register. Reset clears calibration and stored values.
//  m_tready low holds the result; s_tready stays low until it moves.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bptc_pkg::RAW_W-1:0]    s_tdata,    // [23:0] raw_sample
    input  logic                          s_tuser,    // [0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bptc_pkg::VAL_W-1:0]    m_tdata,    // [31:0] result_value
    output logic [1:0]                    m_tuser,    // [0] result_kind, [1] held
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bptc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bptc_pkg::CAL_W-1:0]    cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int MW = bptc_pkg::MW;
    localparam int BW = bptc_pkg::BW;

    logic [bptc_pkg::CAL_W-1:0] cal_reg [bptc_pkg::CAL_N];

    logic [1:0]                          state_reg, state_next;
    logic [2:0]                          step_reg, step_next;
    logic [bptc_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [MW-1:0]                a_reg, a_next;
    logic signed [BW-1:0]                b_reg, b_next;
    logic signed [MW-1:0]                acc_reg, acc_next;
    logic signed [MW-1:0]                off_reg, off_next;
    logic signed [MW-1:0]                sens_reg, sens_next;
    logic signed [bptc_pkg::DT_W-1:0]    dt_reg, dt_next;
    logic signed [bptc_pkg::VAL_W-1:0]   ct_reg, ct_next;
    logic signed [bptc_pkg::VAL_W-1:0]   lp_reg, lp_next;
    logic [bptc_pkg::RAW_W-1:0]          raw_reg, raw_next;
    logic                                op_reg, op_next;
    logic                                held_reg, held_next;
    logic                                mv_reg, mv_next;
    logic [bptc_pkg::VAL_W-1:0]          mdata_reg, mdata_next;
    logic [1:0]                          muser_reg, muser_next;

    logic                                s_fire;
    logic signed [bptc_pkg::DT_W-1:0]    dt_new;
    logic signed [BW-1:0]                ctm, ctp;
    logic signed [MW-1:0]                ctm_w, ctp_w, addend, prod, t_new, p_w, t_sq;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;

    assign dt_new = $signed({2'b00, s_tdata})
                  - $signed({2'b00, cal_reg[bptc_pkg::REG_C5], 8'h00});
    assign ctm    = BW'(ct_reg) - BW'(bptc_pkg::TEMP_KNEE);
    assign ctp    = BW'(ct_reg) - BW'(bptc_pkg::COLD_KNEE);
    assign ctm_w  = MW'(ctm);
    assign ctp_w  = MW'(ctp);

    // serial multiplier step: last bit of b carries negative weight
    always_comb
    begin
        if (!b_reg[0])
            addend = '0;
        else if (cnt_reg == bptc_pkg::MUL_LAST)
            addend = -a_reg;
        else
            addend = a_reg;
    end
    assign prod  = acc_reg + addend;
    assign t_new = MW'(bptc_pkg::TEMP_KNEE) + (prod >>> 23);
    assign t_sq  = prod >>> 31;
    assign p_w   = ((prod >>> 21) - off_reg) >>> 15;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        off_next   = off_reg;
        sens_next  = sens_reg;
        dt_next    = dt_reg;
        ct_next    = ct_reg;
        lp_next    = lp_reg;
        raw_next   = raw_reg;
        op_next    = op_reg;
        held_next  = held_reg;
        mv_next    = mv_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;

        if (mv_reg && m_tready)
            mv_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    op_next  = s_tuser;
                    raw_next = s_tdata;
                    if (s_tdata == '0)
                    begin
                        held_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        held_next  = 1'b0;
                        state_next = S_LOAD;
                        if (s_tuser == bptc_pkg::OP_TEMP)
                        begin
                            dt_next   = dt_new;
                            step_next = bptc_pkg::STEP_T_COEF;
                        end
                        else
                            step_next = bptc_pkg::STEP_P_OFF;
                    end
                end
            end
            S_LOAD:
            begin
                cnt_next   = '0;
                acc_next   = '0;
                state_next = S_MUL;
                case (step_reg)
                    bptc_pkg::STEP_T_COEF:
                    begin
                        a_next = MW'(dt_reg);
                        b_next = BW'({1'b0, cal_reg[bptc_pkg::REG_C6]});
                    end
                    bptc_pkg::STEP_T_SQ:
                    begin
                        a_next = MW'(dt_reg);
                        b_next = BW'(dt_reg);
                    end
                    bptc_pkg::STEP_P_OFF:
                    begin
                        a_next = MW'(dt_reg);
                        b_next = BW'({1'b0, cal_reg[bptc_pkg::REG_C4]});
                    end
                    bptc_pkg::STEP_P_SENS:
                    begin
                        a_next = MW'(dt_reg);
                        b_next = BW'({1'b0, cal_reg[bptc_pkg::REG_C3]});
                    end
                    bptc_pkg::STEP_P_SQ:
                    begin
                        if (ct_reg < bptc_pkg::TEMP_KNEE)
                        begin
                            a_next = (ctm_w <<< 2) + ctm_w;
                            b_next = ctm;
                        end
                        else
                        begin
                            step_next  = bptc_pkg::STEP_P_FINAL;
                            state_next = S_LOAD;
                        end
                    end
                    bptc_pkg::STEP_P_SQ2_OF:
                    begin
                        if (ct_reg < bptc_pkg::COLD_KNEE)
                        begin
                            a_next = (ctp_w <<< 3) - ctp_w;
                            b_next = ctp;
                        end
                        else
                        begin
                            step_next  = bptc_pkg::STEP_P_FINAL;
                            state_next = S_LOAD;
                        end
                    end
                    bptc_pkg::STEP_P_SQ2_SN:
                    begin
                        a_next = (ctp_w <<< 3) + (ctp_w <<< 1) + ctp_w;
                        b_next = ctp;
                    end
                    default:
                    begin
                        a_next = sens_reg;
                        b_next = BW'({1'b0, raw_reg});
                    end
                endcase
            end
            S_MUL:
            begin
                acc_next = prod;
                a_next   = a_reg <<< 1;
                b_next   = b_reg >>> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == bptc_pkg::MUL_LAST)
                begin
                    state_next = S_LOAD;
                    step_next  = step_reg + 1'b1;
                    case (step_reg)
                        bptc_pkg::STEP_T_COEF:
                        begin
                            ct_next = t_new[bptc_pkg::VAL_W-1:0];
                            if (t_new >= MW'(bptc_pkg::TEMP_KNEE))
                                state_next = S_DONE;
                        end
                        bptc_pkg::STEP_T_SQ:
                        begin
                            ct_next    = ct_reg - t_sq[bptc_pkg::VAL_W-1:0];
                            state_next = S_DONE;
                        end
                        bptc_pkg::STEP_P_OFF:
                            off_next = $signed(MW'(cal_reg[bptc_pkg::REG_C2]) <<< 16)
                                     + (prod >>> 7);
                        bptc_pkg::STEP_P_SENS:
                            sens_next = $signed(MW'(cal_reg[bptc_pkg::REG_C1]) <<< 15)
                                      + (prod >>> 8);
                        bptc_pkg::STEP_P_SQ:
                        begin
                            off_next  = off_reg - (prod >>> 1);
                            sens_next = sens_reg - (prod >>> 2);
                        end
                        bptc_pkg::STEP_P_SQ2_OF:
                            off_next = off_reg - prod;
                        bptc_pkg::STEP_P_SQ2_SN:
                            sens_next = sens_reg - (prod >>> 1);
                        default:
                        begin
                            lp_next    = p_w[bptc_pkg::VAL_W-1:0];
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            default:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mdata_next = (op_reg == bptc_pkg::OP_TEMP) ? ct_reg : lp_reg;
                    muser_next = {held_reg, op_reg};
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= bptc_pkg::STEP_T_COEF;
            cnt_reg   <= '0;
            dt_reg    <= '0;
            ct_reg    <= '0;
            lp_reg    <= '0;
            mv_reg    <= 1'b0;
            for (int i = 0; i < bptc_pkg::CAL_N; i++)
                cal_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            dt_reg    <= dt_next;
            ct_reg    <= ct_next;
            lp_reg    <= lp_next;
            mv_reg    <= mv_next;
            if (cfg_valid && cfg_ready &&
                cfg_index < bptc_pkg::IDX_W'(bptc_pkg::CAL_N))
                cal_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        off_reg   <= off_next;
        sens_reg  <= sens_next;
        raw_reg   <= raw_next;
        op_reg    <= op_next;
        held_reg  <= held_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

`ifndef SYNTHESIS
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> state_reg != S_IDLE)
        else $error("accepted word did not start work");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= bptc_pkg::MUL_LAST + 1'b1)
        else $error("multiplier count overran");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside done");
`endif

endmodule
